>>> design/palindrome_seed_swap_search_defines.svh
// ----------------------------------------------------------------------------
// Palindrome seed swap search assertion macros
// Shared concurrent assertion wrappers, clocked on i_clk.
// ----------------------------------------------------------------------------
`ifndef PALINDROME_SEED_SWAP_SEARCH_DEFINES_SVH
`define PALINDROME_SEED_SWAP_SEARCH_DEFINES_SVH

// Check a property while out of reset.
`define PSS_ASSERT(label, prop, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) prop) else $error(msg);

// Check a property on every edge, reset included.
`define PSS_ASSERT_ALWAYS(label, prop, msg) \
    label: assert property (@(posedge i_clk) prop) else $error(msg);

`endif

>>> design/pss_pkg.sv
// ----------------------------------------------------------------------------
// Palindrome seed swap search package
// Shared constants and the command/status bundles between controller and
// datapath.
// ----------------------------------------------------------------------------
package pss_pkg;

    localparam int PSS_MAX_LEN   = 64;
    localparam int PSS_LANES     = 4;
    localparam int PSS_SEED_W    = 64;
    localparam int PSS_LEN_W     = 7;
    localparam int PSS_IDX_W     = 6;
    localparam int PSS_SWAP_W    = 5;
    localparam logic [PSS_LEN_W-1:0] PSS_LEN_RESET = 7'd51;

    typedef struct packed {
        logic                 load;
        logic                 clr_acc;
        logic                 build;
        logic                 step;
        logic                 score_base;
        logic                 score_cand;
        logic                 load_out;
        logic [PSS_IDX_W-1:0] idx_i;
        logic [PSS_IDX_W-1:0] idx_j;
        logic [PSS_LEN_W-1:0] shift;
    } t_pss_cmd;

    typedef struct packed {
        logic                 differ;
        logic [PSS_LEN_W-1:0] len;
        logic [PSS_IDX_W-1:0] half;
    } t_pss_status;

endpackage

>>> design/pss_if.sv
// ----------------------------------------------------------------------------
// Palindrome seed swap search channel interfaces
// Valid/ready channels for seeds, results and the length register write.
// ----------------------------------------------------------------------------
interface pss_seed_if;
    logic        valid;
    logic        ready;
    logic [63:0] seed_bits;

    modport source (output valid, output seed_bits, input ready);
    modport sink   (input valid, input seed_bits, output ready);
endinterface

interface pss_result_if;
    logic        valid;
    logic        ready;
    logic [63:0] best_seed;
    logic [63:0] best_complexity;
    logic [4:0]  swap_first;
    logic [4:0]  swap_second;
    logic        improved;

    modport source (output valid, output best_seed, output best_complexity,
                    output swap_first, output swap_second, output improved,
                    input ready);
    modport sink   (input valid, input best_seed, input best_complexity,
                    input swap_first, input swap_second, input improved,
                    output ready);
endinterface

interface pss_cfg_if;
    logic       valid;
    logic       ready;
    logic [6:0] seed_len;

    modport source (output valid, output seed_len, input ready);
    modport sink   (input valid, input seed_len, output ready);
endinterface

>>> design/pss_datapath.sv
// ----------------------------------------------------------------------------
// Palindrome seed swap search datapath
// Holds the seed, the candidate, the lane popcounts, the saturating score
// accumulator and the best-so-far and output registers.
// ----------------------------------------------------------------------------
module pss_datapath #(
    parameter int MAX_LEN = pss_pkg::PSS_MAX_LEN
) (
    input  logic                                  i_clk,
    input  logic                                  i_rst_n,
    input  pss_pkg::t_pss_cmd                     i_cmd,
    input  logic [pss_pkg::PSS_SEED_W-1:0]        i_seed_bits,
    input  logic [pss_pkg::PSS_LEN_W-1:0]         i_seed_len,
    output pss_pkg::t_pss_status                  o_status,
    output logic [pss_pkg::PSS_SEED_W-1:0]        o_best_seed,
    output logic [pss_pkg::PSS_SEED_W-1:0]        o_best_complexity,
    output logic [pss_pkg::PSS_SWAP_W-1:0]        o_swap_first,
    output logic [pss_pkg::PSS_SWAP_W-1:0]        o_swap_second,
    output logic                                  o_improved
);
    import pss_pkg::*;

    localparam logic [PSS_LEN_W-1:0] LenCap = PSS_LEN_W'(MAX_LEN);

    logic [PSS_LEN_W-1:0]  r_len;
    logic [PSS_SEED_W-1:0] r_seed;
    logic [PSS_SEED_W-1:0] r_cand;
    logic [PSS_SEED_W-1:0] r_acc;
    logic [5:0]            r_cnt    [PSS_LANES];
    logic [PSS_LANES-1:0]  r_lane_v;
    logic                  r_cnt_v;
    logic [PSS_SEED_W-1:0] r_best_seed;
    logic [PSS_SEED_W-1:0] r_best_cx;
    logic [PSS_SWAP_W-1:0] r_bi;
    logic [PSS_SWAP_W-1:0] r_bj;
    logic                  r_imp;
    logic [PSS_SEED_W-1:0] r_o_seed;
    logic [PSS_SEED_W-1:0] r_o_cx;
    logic [PSS_SWAP_W-1:0] r_o_first;
    logic [PSS_SWAP_W-1:0] r_o_second;
    logic                  r_o_imp;

    logic [PSS_LEN_W-1:0]  len_eff;
    logic [PSS_SEED_W-1:0] seed_masked;
    logic [PSS_SEED_W-1:0] n_cand;
    logic [PSS_LEN_W-1:0]  mir_i;
    logic [PSS_LEN_W-1:0]  mir_j;
    logic                  bit_a;
    logic                  bit_b;
    logic [PSS_LEN_W-1:0]  lane_sh  [PSS_LANES];
    logic [5:0]            lane_cnt [PSS_LANES];
    logic [PSS_LANES-1:0]  lane_ok;
    logic [PSS_SEED_W+2:0] acc_sum;
    logic [PSS_SEED_W-1:0] acc_sat;

    // Length clamp and mask of the incoming seed
    always_comb begin
        len_eff     = (i_seed_len > LenCap) ? LenCap : i_seed_len;
        seed_masked = i_seed_bits & ~({PSS_SEED_W{1'b1}} << len_eff);
    end

    // Candidate: exchange bits i and j, copy the new values to the mirrors
    always_comb begin
        bit_a  = r_seed[i_cmd.idx_i];
        bit_b  = r_seed[i_cmd.idx_j];
        mir_i  = r_len - PSS_LEN_W'(1) - PSS_LEN_W'(i_cmd.idx_i);
        mir_j  = r_len - PSS_LEN_W'(1) - PSS_LEN_W'(i_cmd.idx_j);
        n_cand = r_seed;
        n_cand[i_cmd.idx_i]  = bit_b;
        n_cand[mir_i[5:0]]   = bit_b;
        n_cand[i_cmd.idx_j]  = bit_a;
        n_cand[mir_j[5:0]]   = bit_a;
    end

    // One popcount lane per shift of the current step
    always_comb begin
        for (int k = 0; k < PSS_LANES; k++) begin
            lane_sh[k]  = i_cmd.shift + PSS_LEN_W'(k);
            lane_ok[k]  = lane_sh[k] < r_len;
            lane_cnt[k] = 6'($countones(r_cand & (r_cand >> lane_sh[k])));
        end
    end

    // Saturating sum of the lane terms into the accumulator
    always_comb begin
        acc_sum = {3'b000, r_acc};
        for (int k = 0; k < PSS_LANES; k++) begin
            if (r_lane_v[k]) begin
                acc_sum = acc_sum + ((PSS_SEED_W+3)'(1) << r_cnt[k]);
            end
        end
        acc_sat = (acc_sum[PSS_SEED_W+2:PSS_SEED_W] != 3'b000) ?
                  {PSS_SEED_W{1'b1}} : acc_sum[PSS_SEED_W-1:0];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cnt_v <= 1'b0;
        end else begin
            r_cnt_v <= i_cmd.step;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_len  <= len_eff;
            r_seed <= seed_masked;
            r_cand <= seed_masked;
        end else if (i_cmd.build) begin
            r_cand <= n_cand;
        end

        if (i_cmd.step) begin
            for (int k = 0; k < PSS_LANES; k++) begin
                r_cnt[k] <= lane_cnt[k];
            end
            r_lane_v <= lane_ok;
        end

        if (i_cmd.clr_acc) begin
            r_acc <= '0;
        end else if (r_cnt_v) begin
            r_acc <= acc_sat;
        end

        if (i_cmd.score_base) begin
            r_best_seed <= r_cand;
            r_best_cx   <= r_acc;
            r_bi        <= '0;
            r_bj        <= '0;
            r_imp       <= 1'b0;
        end else if (i_cmd.score_cand && (r_acc < r_best_cx)) begin
            r_best_seed <= r_cand;
            r_best_cx   <= r_acc;
            r_bi        <= i_cmd.idx_i[PSS_SWAP_W-1:0];
            r_bj        <= i_cmd.idx_j[PSS_SWAP_W-1:0];
            r_imp       <= 1'b1;
        end

        if (i_cmd.load_out) begin
            r_o_seed   <= r_best_seed;
            r_o_cx     <= r_best_cx;
            r_o_first  <= r_bi;
            r_o_second <= r_bj;
            r_o_imp    <= r_imp;
        end
    end

    always_comb begin
        o_status.differ = bit_a ^ bit_b;
        o_status.len    = r_len;
        o_status.half   = r_len[PSS_LEN_W-1:1];
    end

    assign o_best_seed       = r_o_seed;
    assign o_best_complexity = r_o_cx;
    assign o_swap_first      = r_o_first;
    assign o_swap_second     = r_o_second;
    assign o_improved        = r_o_imp;

endmodule

>>> design/pss_ctrl.sv
// ----------------------------------------------------------------------------
// Palindrome seed swap search controller
// Walks the base score, then every half-position pair, and hands the
// result to the output register.
// ----------------------------------------------------------------------------
`include "palindrome_seed_swap_search_defines.svh"

module pss_ctrl (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_in_valid,
    output logic                 o_in_ready,
    output logic                 o_out_valid,
    input  logic                 i_out_ready,
    input  pss_pkg::t_pss_status i_status,
    output pss_pkg::t_pss_cmd    o_cmd
);
    import pss_pkg::*;

    localparam logic [2:0] ST_IDLE = 3'd0;
    localparam logic [2:0] ST_EVAL = 3'd1;
    localparam logic [2:0] ST_CMP  = 3'd2;
    localparam logic [2:0] ST_PAIR = 3'd3;
    localparam logic [2:0] ST_FIN  = 3'd4;

    logic [2:0]           r_state, n_state;
    logic                 r_base,  n_base;
    logic [PSS_IDX_W-1:0] r_i,     n_i;
    logic [PSS_IDX_W-1:0] r_j,     n_j;
    logic [PSS_LEN_W-1:0] r_sh,    n_sh;
    logic                 r_out_valid, n_out_valid;
    logic                 in_fire;
    logic                 out_free;

    assign in_fire  = i_in_valid && (r_state == ST_IDLE);
    assign out_free = !r_out_valid || i_out_ready;

    always_comb begin
        n_state     = r_state;
        n_base      = r_base;
        n_i         = r_i;
        n_j         = r_j;
        n_sh        = r_sh;
        n_out_valid = r_out_valid && !i_out_ready;
        o_cmd       = '0;
        o_cmd.idx_i = r_i;
        o_cmd.idx_j = r_j;
        o_cmd.shift = r_sh;

        unique case (r_state)
            ST_IDLE: begin
                if (i_in_valid) begin
                    o_cmd.load    = 1'b1;
                    o_cmd.clr_acc = 1'b1;
                    n_sh          = PSS_LEN_W'(1);
                    n_base        = 1'b1;
                    n_state       = ST_EVAL;
                end
            end
            ST_EVAL: begin
                if (r_sh < i_status.len) begin
                    o_cmd.step = 1'b1;
                    n_sh       = r_sh + PSS_LEN_W'(PSS_LANES);
                end else begin
                    n_state = ST_CMP;
                end
            end
            ST_CMP: begin
                o_cmd.score_base = r_base;
                o_cmd.score_cand = !r_base;
                if (r_base) begin
                    n_base = 1'b0;
                    n_i    = '0;
                    n_j    = PSS_IDX_W'(1);
                end else begin
                    n_j = r_j + PSS_IDX_W'(1);
                end
                n_state = ST_PAIR;
            end
            ST_PAIR: begin
                if (r_j < i_status.half) begin
                    if (i_status.differ) begin
                        o_cmd.build   = 1'b1;
                        o_cmd.clr_acc = 1'b1;
                        n_sh          = PSS_LEN_W'(1);
                        n_state       = ST_EVAL;
                    end else begin
                        n_j = r_j + PSS_IDX_W'(1);
                    end
                end else if ((r_i + PSS_IDX_W'(1)) < i_status.half) begin
                    n_i = r_i + PSS_IDX_W'(1);
                    n_j = r_i + PSS_IDX_W'(2);
                end else begin
                    n_state = ST_FIN;
                end
            end
            ST_FIN: begin
                if (out_free) begin
                    o_cmd.load_out = 1'b1;
                    n_out_valid    = 1'b1;
                    n_state        = ST_IDLE;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_base      <= 1'b0;
            r_i         <= '0;
            r_j         <= '0;
            r_sh        <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_base      <= n_base;
            r_i         <= n_i;
            r_j         <= n_j;
            r_sh        <= n_sh;
            r_out_valid <= n_out_valid;
        end
    end

    assign o_in_ready  = (r_state == ST_IDLE);
    assign o_out_valid = r_out_valid;

    `PSS_ASSERT(a_accept_starts_base, in_fire |=> (r_state == ST_EVAL) && r_base, "accept must start the base score")
    `PSS_ASSERT(a_step_in_range, o_cmd.step |-> (r_sh < i_status.len), "shift step beyond seed length")
    `PSS_ASSERT(a_cmp_after_eval, (r_state == ST_CMP) |-> ($past(r_state) == ST_EVAL), "compare without a finished score")
    `PSS_ASSERT(a_pair_order, (r_state == ST_EVAL) && !r_base |-> (r_i < r_j) && (r_j < i_status.half), "candidate pair out of order")
    `PSS_ASSERT_ALWAYS(a_reset_idle, !i_rst_n |=> (r_state == ST_IDLE) && !r_out_valid, "reset must leave the block idle")

endmodule

>>> design/palindrome_seed_swap_search.sv
// ----------------------------------------------------------------------------
// Palindrome seed swap search
// Scores a palindromic spaced seed by overlap complexity and searches every
// mirrored swap of two differing half positions for the first strict minimum.
// ----------------------------------------------------------------------------
// Order: the base score of the seed beat, then one candidate score per
//   differing pair tried in the pair walk, then the result beat.
// Throughput: one seed at a time; the score of each candidate steps through
//   the shifts in groups of four, set by the four popcount lanes of the datapath.
// Reset: synchronous, active low; idles the controller, empties the output
//   register and sets the length register to 51.
// ----------------------------------------------------------------------------
module palindrome_seed_swap_search #(
    parameter int MAX_LEN = pss_pkg::PSS_MAX_LEN
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    pss_seed_if.sink    i_seed,
    pss_result_if.source o_result,
    pss_cfg_if.sink     i_cfg
);
    import pss_pkg::*;

    // Length register; to be written only while idle (not enforced here), so always accept the beat
    logic [PSS_LEN_W-1:0] r_seed_len;

    t_pss_cmd    cmd;
    t_pss_status status;

    assign i_cfg.ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_seed_len <= PSS_LEN_RESET;
        end else if (i_cfg.valid) begin
            r_seed_len <= i_cfg.seed_len;
        end
    end

    // Controller: sequence the base score, the pair walk and the hand-off
    // into the output register. The output register lets a new seed start
    // while the previous result still waits on the result channel.
    pss_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_seed.valid),
        .o_in_ready  (i_seed.ready),
        .o_out_valid (o_result.valid),
        .i_out_ready (o_result.ready),
        .i_status    (status),
        .o_cmd       (cmd)
    );

    // Datapath: clamp and mask the seed, build candidates, sum the shift
    // terms with saturation and keep the best candidate so far
    pss_datapath #(
        .MAX_LEN (MAX_LEN)
    ) u_datapath (
        .i_clk             (i_clk),
        .i_rst_n           (i_rst_n),
        .i_cmd             (cmd),
        .i_seed_bits       (i_seed.seed_bits),
        .i_seed_len        (r_seed_len),
        .o_status          (status),
        .o_best_seed       (o_result.best_seed),
        .o_best_complexity (o_result.best_complexity),
        .o_swap_first      (o_result.swap_first),
        .o_swap_second     (o_result.swap_second),
        .o_improved        (o_result.improved)
    );

endmodule
